### hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is low.
`define CHK_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, checked while reset is low.
`define CHK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Condition that must hold in the cycle after reset is seen.
`define CHK_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("post-reset check failed");

`endif

### hdl/kdop_pkg.sv
// Types and constants of the 18-DOP point accumulator.
package kdop_pkg;

   localparam int COORD_BITS = 24;
   localparam int SLAB_BITS  = COORD_BITS + 1;
   localparam int SLAB_COUNT = 9;

   // Request codes; the fourth code is unused and leaves the volume alone.
   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_TEST  = 2'd2
   } req_kind_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [COORD_BITS-1:0]        extent_type;
   typedef logic signed [SLAB_BITS-1:0]  slab_type;
   typedef logic [SLAB_COUNT-1:0][SLAB_BITS-1:0] slab_vec_type;

   // Empty volume: every low bound at the top, every high bound at the bottom.
   localparam slab_type SLAB_LOW_INIT  = {1'b0, {COORD_BITS{1'b1}}};
   localparam slab_type SLAB_HIGH_INIT = {1'b1, {COORD_BITS{1'b0}}};

   // Slab order: x, y, z, x+y, x+z, y+z, x-y, x-z, y-z.
   localparam int SLAB_X = 0;
   localparam int SLAB_Y = 1;
   localparam int SLAB_Z = 2;

   typedef struct packed {
      logic [1:0] req_type;
      coord_type  coord_x;
      coord_type  coord_y;
      coord_type  coord_z;
   } point_beat_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } stage_ctl_type;

   typedef struct packed {
      logic       inside_res;
      logic       is_empty;
      extent_type extent_x;
      extent_type extent_y;
      extent_type extent_z;
      coord_type  middle_x;
      coord_type  middle_y;
      coord_type  middle_z;
   } result_type;

endpackage

### hdl/kdop_ifs.sv
// Request and response channel interfaces of the 18-DOP accumulator.
interface kdop_req_if;
   import kdop_pkg::*;

   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   coord_type  coord_x;
   coord_type  coord_y;
   coord_type  coord_z;

   modport source (output valid, req_type, coord_x, coord_y, coord_z, input ready);
   modport sink   (input valid, req_type, coord_x, coord_y, coord_z, output ready);
endinterface

interface kdop_rsp_if;
   import kdop_pkg::*;

   logic       valid;
   logic       ready;
   logic       inside_res;
   logic       is_empty;
   extent_type extent_x;
   extent_type extent_y;
   extent_type extent_z;
   coord_type  middle_x;
   coord_type  middle_y;
   coord_type  middle_z;

   modport source (output valid, inside_res, is_empty, extent_x, extent_y, extent_z,
                   middle_x, middle_y, middle_z, input ready);
   modport sink   (input valid, inside_res, is_empty, extent_x, extent_y, extent_z,
                   middle_x, middle_y, middle_z, output ready);
endinterface

### hdl/kdop_slab.sv
// Slab store: forms the nine slab values of a point, clears, widens or tests the slabs.
module kdop_slab (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   beat_valid,
   input  kdop_pkg::point_beat_type beat,
   output kdop_pkg::slab_vec_type slab_low,
   output kdop_pkg::slab_vec_type slab_high,
   output kdop_pkg::stage_ctl_type stage
);
   import kdop_pkg::*;

   slab_vec_type  low_ff,   low_in;
   slab_vec_type  high_ff,  high_in;
   stage_ctl_type stage_ff, stage_in;
   slab_type      ext_x, ext_y, ext_z;
   slab_type      value [SLAB_COUNT];
   logic [SLAB_COUNT-1:0] in_slab;

   // Sign-extend the coordinates one bit so every diagonal fits.
   assign ext_x = {beat.coord_x[COORD_BITS-1], beat.coord_x};
   assign ext_y = {beat.coord_y[COORD_BITS-1], beat.coord_y};
   assign ext_z = {beat.coord_z[COORD_BITS-1], beat.coord_z};

   // The three axis values and the six diagonal sums and differences.
   assign value[0] = ext_x;
   assign value[1] = ext_y;
   assign value[2] = ext_z;
   assign value[3] = ext_x + ext_y;
   assign value[4] = ext_x + ext_z;
   assign value[5] = ext_y + ext_z;
   assign value[6] = ext_x - ext_y;
   assign value[7] = ext_x - ext_z;
   assign value[8] = ext_y - ext_z;

   // Per-slab containment and widening, all nine slabs in parallel.
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      for (int i = 0; i < SLAB_COUNT; i++) begin
         in_slab[i] = (value[i] >= $signed(low_ff[i])) && (value[i] <= $signed(high_ff[i]));
         if (beat_valid && (beat.req_type == REQ_CLEAR)) begin
            low_in[i]  = SLAB_LOW_INIT;
            high_in[i] = SLAB_HIGH_INIT;
         end else if (beat_valid && (beat.req_type == REQ_ADD)) begin
            if (value[i] < $signed(low_ff[i])) begin
               low_in[i] = value[i];
            end
            if (value[i] > $signed(high_ff[i])) begin
               high_in[i] = value[i];
            end
         end
      end
   end

   // Stage control: a test is a hit only when all nine slabs contain the point.
   always_comb begin
      stage_in.valid = beat_valid;
      stage_in.hit   = (beat.req_type == REQ_TEST) && (&in_slab);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLAB_COUNT; i++) begin
            low_ff[i]  <= SLAB_LOW_INIT;
            high_ff[i] <= SLAB_HIGH_INIT;
         end
         stage_ff <= '0;
      end else if (advance) begin
         low_ff   <= low_in;
         high_ff  <= high_in;
         stage_ff <= stage_in;
      end
   end

   assign slab_low  = low_ff;
   assign slab_high = high_ff;
   assign stage     = stage_ff;
endmodule

### hdl/kdop_report.sv
// Result stage: empty flag, axis extents and centers, registered for output.
module kdop_report (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  kdop_pkg::stage_ctl_type stage,
   input  kdop_pkg::slab_vec_type  slab_low,
   input  kdop_pkg::slab_vec_type  slab_high,
   output logic                    rsp_valid,
   output kdop_pkg::result_type    result
);
   import kdop_pkg::*;

   logic       valid_ff,  valid_in;
   result_type result_ff, result_in;
   logic       empty;
   slab_type   diff [3];
   logic signed [SLAB_BITS:0] total [3];
   extent_type extent [3];
   coord_type  middle [3];

   // The volume is empty while the x low bound lies above the x high bound.
   assign empty = $signed(slab_low[SLAB_X]) > $signed(slab_high[SLAB_X]);

   // Extent and floor-halved center of each axis slab.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i]  = $signed(slab_high[i]) - $signed(slab_low[i]);
         total[i] = {slab_high[i][SLAB_BITS-1], slab_high[i]}
                  + {slab_low[i][SLAB_BITS-1], slab_low[i]};
         extent[i] = empty ? '0 : diff[i][COORD_BITS-1:0];
         middle[i] = empty ? '0 : total[i][COORD_BITS:1];
      end
   end

   always_comb begin
      valid_in             = stage.valid;
      result_in.inside_res = stage.hit;
      result_in.is_empty   = empty;
      result_in.extent_x   = extent[SLAB_X];
      result_in.extent_y   = extent[SLAB_Y];
      result_in.extent_z   = extent[SLAB_Z];
      result_in.middle_x   = middle[SLAB_X];
      result_in.middle_y   = middle[SLAB_Y];
      result_in.middle_z   = middle[SLAB_Z];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign result    = result_ff;
endmodule

### hdl/kdop18_point_accumulate_test.sv
// A request beat goes through the input, slab and result registers to its response beat.
// Throughput: one beat per cycle; the three stages (input register, slab update,
// result register) all move together and hold only while the response beat waits.
// Reset: all slabs return to the empty volume and no beat is held in any stage.
// Each response describes the volume as it stands after its own request.
module kdop18_point_accumulate_test (
   input logic      clock,
   input logic      reset,
   kdop_req_if.sink   req_bus,
   kdop_rsp_if.source rsp_bus
);
   import kdop_pkg::*;

   logic           advance;
   logic           in_valid_ff, in_valid_in;
   point_beat_type in_beat_ff,  in_beat_in;
   slab_vec_type   slab_low, slab_high;
   stage_ctl_type  stage;
   logic           rsp_valid;
   result_type     result;

   // The pipeline moves whenever the output register is free or being drained.
   assign advance       = !rsp_valid || rsp_bus.ready;
   assign req_bus.ready = advance;

   // Input register.
   always_comb begin
      in_valid_in         = req_bus.valid;
      in_beat_in.req_type = req_bus.req_type;
      in_beat_in.coord_x  = req_bus.coord_x;
      in_beat_in.coord_y  = req_bus.coord_y;
      in_beat_in.coord_z  = req_bus.coord_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_beat_ff <= in_beat_in;
      end
   end

   kdop_slab u_slab (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .beat_valid (in_valid_ff),
      .beat       (in_beat_ff),
      .slab_low   (slab_low),
      .slab_high  (slab_high),
      .stage      (stage)
   );

   kdop_report u_report (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .stage     (stage),
      .slab_low  (slab_low),
      .slab_high (slab_high),
      .rsp_valid (rsp_valid),
      .result    (result)
   );

   // Response channel.
   assign rsp_bus.valid      = rsp_valid;
   assign rsp_bus.inside_res = result.inside_res;
   assign rsp_bus.is_empty   = result.is_empty;
   assign rsp_bus.extent_x   = result.extent_x;
   assign rsp_bus.extent_y   = result.extent_y;
   assign rsp_bus.extent_z   = result.extent_z;
   assign rsp_bus.middle_x   = result.middle_x;
   assign rsp_bus.middle_y   = result.middle_y;
   assign rsp_bus.middle_z   = result.middle_z;
endmodule

### hdl/kdop_checker.sv
// Port-level checks of the 18-DOP accumulator and their binding to the top level.
`include "assert_macros.svh"

module kdop_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       inside_res,
   input logic                       is_empty,
   input kdop_pkg::extent_type       extent_x,
   input kdop_pkg::extent_type       extent_y,
   input kdop_pkg::extent_type       extent_z,
   input kdop_pkg::coord_type        middle_x,
   input kdop_pkg::coord_type        middle_y,
   input kdop_pkg::coord_type        middle_z
);
   import kdop_pkg::*;

   // No response beat may be left over from before reset.
   `CHK_AFTER_RESET(a_no_rsp_after_reset, !rsp_valid)

   // A stalled response beat stays offered.
   `CHK_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid)

   // An empty volume reports zero extents and centers.
   `CHK_IMPLY(a_empty_zero, rsp_valid && is_empty, (extent_x == '0) && (extent_y == '0) && (extent_z == '0) && (middle_x == '0) && (middle_y == '0) && (middle_z == '0))

   // No point can lie inside an empty volume.
   `CHK_IMPLY(a_inside_not_empty, rsp_valid && inside_res, !is_empty)
endmodule

bind kdop18_point_accumulate_test kdop_checker u_kdop_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .inside_res (rsp_bus.inside_res),
   .is_empty   (rsp_bus.is_empty),
   .extent_x   (rsp_bus.extent_x),
   .extent_y   (rsp_bus.extent_y),
   .extent_z   (rsp_bus.extent_z),
   .middle_x   (rsp_bus.middle_x),
   .middle_y   (rsp_bus.middle_y),
   .middle_z   (rsp_bus.middle_z)
);
